// ===== hdl/dtnc_pkg.sv =====
// ----------------------------------------------------------------------------
// dtnc_pkg
// Types, class codes and bound constants for the numeric class converter
// ----------------------------------------------------------------------------
package dtnc_pkg;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        is_imag;
    logic [3:0]  target_class;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        part_dropped;
  } out_beat_t;

  // class codes
  localparam logic [3:0] CLS_DOUBLE  = 4'd0;
  localparam logic [3:0] CLS_SINGLE  = 4'd1;
  localparam logic [3:0] CLS_LOGICAL = 4'd2;
  localparam logic [3:0] CLS_INT8    = 4'd3;
  localparam logic [3:0] CLS_INT16   = 4'd4;
  localparam logic [3:0] CLS_INT32   = 4'd5;
  localparam logic [3:0] CLS_INT64   = 4'd6;
  localparam logic [3:0] CLS_UINT8   = 4'd7;
  localparam logic [3:0] CLS_UINT16  = 4'd8;
  localparam logic [3:0] CLS_UINT32  = 4'd9;
  localparam logic [3:0] CLS_UINT64  = 4'd10;

  // double bit patterns
  localparam logic [63:0] D_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] D_P127    = 64'h405F_C000_0000_0000;
  localparam logic [63:0] D_M128    = 64'hC060_0000_0000_0000;
  localparam logic [63:0] D_P32767  = 64'h40DF_FFC0_0000_0000;
  localparam logic [63:0] D_M32768  = 64'hC0E0_0000_0000_0000;
  localparam logic [63:0] D_PI32MAX = 64'h41DF_FFFF_FFC0_0000;
  localparam logic [63:0] D_MI32MIN = 64'hC1E0_0000_0000_0000;
  localparam logic [63:0] D_P2P63   = 64'h43E0_0000_0000_0000;
  localparam logic [63:0] D_M2P63   = 64'hC3E0_0000_0000_0000;
  localparam logic [63:0] D_P255    = 64'h406F_E000_0000_0000;
  localparam logic [63:0] D_P65535  = 64'h40EF_FFE0_0000_0000;
  localparam logic [63:0] D_PU32MAX = 64'h41EF_FFFF_FFE0_0000;
  localparam logic [63:0] D_P2P64   = 64'h43F0_0000_0000_0000;

  // saturated result of an integer class
  function automatic logic [63:0] sat_value(input logic [3:0] cls, input logic neg);
    logic [63:0] r;
    r = '0;
    case (cls)
      CLS_INT8:   r = neg ? D_M128    : D_P127;
      CLS_INT16:  r = neg ? D_M32768  : D_P32767;
      CLS_INT32:  r = neg ? D_MI32MIN : D_PI32MAX;
      CLS_INT64:  r = neg ? D_M2P63   : D_P2P63;
      CLS_UINT8:  r = D_P255;
      CLS_UINT16: r = D_P65535;
      CLS_UINT32: r = D_PU32MAX;
      CLS_UINT64: r = D_P2P64;
      default:    r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/dtnc_f32_norm.sv =====
// ----------------------------------------------------------------------------
// dtnc_f32_norm
// Normalizes a rounded binary32 significand back into a double pattern
// ----------------------------------------------------------------------------
module dtnc_f32_norm (
  input  logic              sign,
  input  logic [24:0]       qr,
  input  logic signed [9:0] k,
  output logic [63:0]       bits
);
  import dtnc_pkg::*;

  logic [4:0]         p;
  logic signed [11:0] ne;
  logic [52:0]        shifted;
  logic [10:0]        bexp;

  always_comb begin
    p = '0;
    for (int i = 0; i < 25; i++) begin
      if (qr[i]) p = 5'(i);
    end
    ne      = 12'(signed'({7'b0, p})) + 12'(k);
    shifted = 53'(qr) << (6'd52 - 6'(p));
    bexp    = 11'(ne + 12'sd1023);
    if (qr == '0) begin
      bits = {sign, 63'b0};
    end else if (ne > 12'sd127) begin
      bits = {sign, 11'h7FF, 52'b0};
    end else begin
      bits = {sign, bexp, shifted[51:0]};
    end
  end

endmodule

// ===== hdl/double_to_numeric_class_convert.sv =====
// ----------------------------------------------------------------------------
// double_to_numeric_class_convert
// Converts one double element part to a numeric class, result as a double
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_stall/in_data carry one element part per beat: the double
//   bit pattern, an imaginary flag and the target class code
//   out_valid/out_stall/out_data return one result beat per input beat, in
//   order: the converted double and a flag set when an imaginary part of an
//   integer or logical class is dropped
//   throughput is one beat per cycle while the output is not stalled; the
//   three register stages are decode and round-add, exponent/saturation
//   select, then normalize into the output register
//   when the receiver stalls a full output register, the whole pipe holds
//   and in_stall rises in the same cycle; bubbles do not stall anything
//   reset (rst_n low, synchronous) clears all stage valid bits; payload
//   registers keep whatever they held
// ----------------------------------------------------------------------------
module double_to_numeric_class_convert (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtnc_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dtnc_pkg::out_beat_t  out_data
);
  import dtnc_pkg::*;

  // stage 1 payload: decoded fields and pre-rounded significands
  typedef struct packed {
    logic               done;     // final result already known
    logic [63:0]        bits;
    logic               dropped;
    logic               is_int;
    logic               is_sgl;
    logic [3:0]         cls;
    logic               sign;
    logic               huge;
    logic [10:0]        ex;
    logic signed [12:0] e;
    logic signed [7:0]  lbound;   // saturate when rounded exponent >= this
    logic               uns;
    logic [53:0]        rnd;
    logic [23:0]        q;
    logic               up;
    logic signed [9:0]  k;
  } s1_t;

  // stage 2 payload
  typedef struct packed {
    logic              is_sgl;
    logic [63:0]       bits;
    logic              dropped;
    logic              sign;
    logic [24:0]       qr;
    logic signed [9:0] k;
  } s2_t;

  logic      en;
  logic      v1_r, v2_r, v3_r;
  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  out_beat_t out_r, out_nxt;

  // global advance: hold everything only when the output beat is blocked
  assign en       = !(v3_r && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: decode, class select, rounding add ----------
  logic [52:0]        sig;
  logic [51:0]        frac;
  logic [10:0]        ex;
  logic signed [12:0] e;
  logic [5:0]         f;
  logic [53:0]        half, mask;
  logic [5:0]         sh;
  logic [52:0]        sig_sh, st_mask;
  logic               guard, sticky;
  logic               sgn;
  logic [3:0]         cls;

  always_comb begin
    frac   = in_data.value_bits[51:0];
    ex     = in_data.value_bits[62:52];
    sgn    = in_data.value_bits[63];
    cls    = in_data.target_class;
    sig    = {1'b1, frac};
    e      = 13'(signed'({2'b0, ex})) - 13'sd1023;
    f      = 6'(13'sd52 - e);
    half   = 54'(1) << (f - 6'd1);
    mask   = (54'(1) << f) - 54'(1);
    sh     = (e >= -13'sd126) ? 6'd29 : 6'(-13'sd97 - e);
    sig_sh = sig >> sh;
    guard  = sig[sh - 6'd1];
    st_mask = (53'(1) << (sh - 6'd1)) - 53'(1);
    sticky = |(sig & st_mask);

    s1_nxt         = '0;
    s1_nxt.cls     = cls;
    s1_nxt.sign    = sgn;
    s1_nxt.ex      = ex;
    s1_nxt.e       = e;
    s1_nxt.bits    = in_data.value_bits;
    s1_nxt.done    = 1'b1;
    s1_nxt.q       = sig_sh[23:0];
    s1_nxt.up      = guard && (sticky || sig_sh[0]);
    s1_nxt.k       = (e >= -13'sd126) ? 10'(e - 13'sd23) : -10'sd149;
    s1_nxt.uns     = (cls >= CLS_UINT8);
    s1_nxt.lbound  = 8'sd0;

    case (cls)
      CLS_INT8:   s1_nxt.lbound = 8'sd7;
      CLS_INT16:  s1_nxt.lbound = 8'sd15;
      CLS_INT32:  s1_nxt.lbound = 8'sd31;
      CLS_INT64:  s1_nxt.lbound = 8'sd63;
      CLS_UINT8:  s1_nxt.lbound = 8'sd8;
      CLS_UINT16: s1_nxt.lbound = 8'sd16;
      CLS_UINT32: s1_nxt.lbound = 8'sd32;
      CLS_UINT64: s1_nxt.lbound = 8'sd64;
      default:    s1_nxt.lbound = 8'sd0;
    endcase

    if ((cls >= CLS_LOGICAL) && (cls <= CLS_UINT64) && in_data.is_imag) begin
      // imaginary part dropped
      s1_nxt.bits    = '0;
      s1_nxt.dropped = 1'b1;
    end else if (cls == CLS_LOGICAL) begin
      s1_nxt.bits = (in_data.value_bits[62:0] != '0) ? D_ONE : '0;
    end else if ((cls >= CLS_INT8) && (cls <= CLS_UINT64)) begin
      s1_nxt.bits = '0;
      if (ex == 11'h7FF) begin
        // nan gives zero, infinity saturates
        s1_nxt.done   = (frac != '0);
        s1_nxt.is_int = (frac == '0);
        s1_nxt.huge   = 1'b1;
      end else if (ex == 11'h000 || e < -13'sd1) begin
        s1_nxt.done = 1'b1;
      end else begin
        s1_nxt.done   = 1'b0;
        s1_nxt.is_int = 1'b1;
        s1_nxt.huge   = (e >= 13'sd64);
        s1_nxt.rnd    = (e >= 13'sd52) ? {1'b0, sig} : (({1'b0, sig} + half) & ~mask);
      end
    end else if (cls == CLS_SINGLE) begin
      if (ex == 11'h7FF) begin
        s1_nxt.bits = (frac == '0) ? in_data.value_bits :
                      {sgn, 11'h7FF, 1'b1, frac[50:29], 29'b0};
      end else if (ex == 11'h000) begin
        s1_nxt.bits = {sgn, 63'b0};
      end else if (e > 13'sd127) begin
        s1_nxt.bits = {sgn, 11'h7FF, 52'b0};
      end else if (e < -13'sd157) begin
        // shift past every significand bit
        s1_nxt.bits = {sgn, 63'b0};
      end else begin
        s1_nxt.done   = 1'b0;
        s1_nxt.is_sgl = 1'b1;
      end
    end
  end

  // ---------------- stage 2: carry, saturation, single increment ---------
  logic               carry;
  logic signed [12:0] re;

  always_comb begin
    carry          = s1_r.rnd[53];
    re             = s1_r.e + 13'(carry);
    s2_nxt         = '0;
    s2_nxt.dropped = s1_r.dropped;
    s2_nxt.sign    = s1_r.sign;
    s2_nxt.k       = s1_r.k;
    s2_nxt.qr      = {1'b0, s1_r.q} + 25'(s1_r.up);
    s2_nxt.is_sgl  = s1_r.is_sgl;
    s2_nxt.bits    = s1_r.bits;
    if (s1_r.is_int) begin
      if (s1_r.sign && s1_r.uns) begin
        s2_nxt.bits = '0;
      end else if (s1_r.huge || re >= 13'(s1_r.lbound)) begin
        s2_nxt.bits = sat_value(s1_r.cls, s1_r.sign);
      end else begin
        s2_nxt.bits = {s1_r.sign, s1_r.ex + 11'(carry),
                       carry ? 52'b0 : s1_r.rnd[51:0]};
      end
    end
  end

  // ---------------- stage 3: binary32 normalize into output ---------------
  logic [63:0] sgl_bits;

  dtnc_f32_norm u_norm (
    .sign (s2_r.sign),
    .qr   (s2_r.qr),
    .k    (s2_r.k),
    .bits (sgl_bits)
  );

  always_comb begin
    out_nxt.result_bits  = s2_r.is_sgl ? sgl_bits : s2_r.bits;
    out_nxt.part_dropped = s2_r.dropped;
  end

  // ---------------- registers ---------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/dtnc_checker.sv =====
// ----------------------------------------------------------------------------
// dtnc_checker
// Port-level checks of the numeric class converter, bound to the top level
// ----------------------------------------------------------------------------
module dtnc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input dtnc_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input dtnc_pkg::out_beat_t out_data
);
  import dtnc_pkg::*;

  // blocked output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("blocked output beat changed");

  // dropped part always reads as zero
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.part_dropped |-> out_data.result_bits == 64'b0)
    else $error("dropped part not zero");

  // input only stalls behind a blocked output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // pipe empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind double_to_numeric_class_convert dtnc_checker u_dtnc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
